FILE: rtl/gbk_pkg.sv
package gbk_pkg;

    // Byte classes
    localparam logic [7:0] PLAIN_LO = 8'h20;
    localparam logic [7:0] PLAIN_HI = 8'h80;
    localparam logic [7:0] LEAD_LO  = 8'h81;
    localparam logic [7:0] LEAD_HI  = 8'hFE;
    localparam logic [7:0] TRAIL_LO = 8'h40;
    localparam logic [7:0] TRAIL_HI = 8'h7E;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Number of beats that one input byte produces
    localparam int          CNT_W     = 3;
    localparam logic [2:0] CNT_NONE  = 3'd0;
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_PAIR  = 3'd2;
    localparam logic [2:0] CNT_ERROR = 3'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       text_done;
        logic       text_ok;
    } t_out_beat;

    // Work handed from the decoder to the emitter
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             err;
        logic             last;
        logic [7:0]       b0;
        logic [7:0]       b1;
    } t_burst;

    // Characters of the error marker "<ERROR>"
    function automatic logic [7:0] err_char(input logic [CNT_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3C;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h52;
            default: c = 8'h3E;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/gbk_byte_stream_validator.sv
// Beats pass the input register, then the emitter's burst register. Throughput:
// one input beat per cycle when the emitter is free; a lead/trail pair goes as
// two beats, a fault seven "<ERROR>" beats, one per unstalled cycle, holding input.
// Bytes that give no output (held lead, dropped bytes) never wait on the output.
// Reset (i_rst_n low, synchronous) empties both stages and clears string state.
module gbk_byte_stream_validator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gbk_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gbk_pkg::t_out_beat o_out_beat
);
    import gbk_pkg::*;

    logic     r_in_vld;
    t_in_beat r_in;

    t_burst burst;
    logic   emit_rdy;
    logic   take;
    logic   in_fire;

    // Input beat moves on when it makes no output or the emitter frees up
    assign take       = r_in_vld && (burst.cnt == CNT_NONE || emit_rdy);
    assign o_in_stall = r_in_vld && !take;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_beat;
        end
    end

    gbk_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (r_in),
        .i_take  (take),
        .o_burst (burst)
    );

    gbk_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take && burst.cnt != CNT_NONE),
        .i_burst     (burst),
        .o_rdy       (emit_rdy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

FILE: rtl/gbk_dec.sv
module gbk_dec (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbk_pkg::t_in_beat i_beat,
    input  logic            i_take,
    output gbk_pkg::t_burst o_burst
);
    import gbk_pkg::*;

    logic       r_lead_pending;
    logic [7:0] r_lead_value;
    logic       r_halted;

    logic       n_lead_pending;
    logic [7:0] n_lead_value;
    logic       n_halted;

    logic [7:0] b;
    logic       last;
    logic       is_plain;
    logic       is_lead;
    logic       is_trail;
    logic       fault;

    assign b    = i_beat.in_byte;
    assign last = i_beat.in_last;

    // Byte classification
    assign is_plain = (b >= PLAIN_LO && b <= PLAIN_HI) || b == CH_CR || b == CH_LF
                      || b == CH_TAB;
    assign is_lead  = b >= LEAD_LO && b <= LEAD_HI;
    assign is_trail = (b >= TRAIL_LO && b <= TRAIL_HI) || (b >= PLAIN_HI && b <= LEAD_HI);

    // Decide the burst and the next state
    always_comb begin
        o_burst        = '0;
        o_burst.last   = last;
        o_burst.b0     = b;
        o_burst.b1     = b;
        fault          = 1'b0;
        n_lead_pending = r_lead_pending;
        n_lead_value   = r_lead_value;
        n_halted       = r_halted;

        if (r_halted) begin
            o_burst.cnt = CNT_NONE;
        end else if (r_lead_pending) begin
            if (is_trail) begin
                o_burst.cnt    = CNT_PAIR;
                o_burst.b0     = r_lead_value;
                n_lead_pending = 1'b0;
                n_lead_value   = '0;
            end else begin
                fault = 1'b1;
            end
        end else if (is_plain) begin
            o_burst.cnt = CNT_ONE;
        end else if (is_lead) begin
            if (last) begin
                fault = 1'b1;
            end else begin
                n_lead_pending = 1'b1;
                n_lead_value   = b;
            end
        end else begin
            fault = 1'b1;
        end

        if (fault) begin
            o_burst.cnt    = CNT_ERROR;
            o_burst.err    = 1'b1;
            n_lead_pending = 1'b0;
            n_lead_value   = '0;
            n_halted       = 1'b1;
        end

        // end of string clears everything
        if (last) begin
            n_lead_pending = 1'b0;
            n_lead_value   = '0;
            n_halted       = 1'b0;
        end
    end

    // Per-string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_value   <= '0;
            r_halted       <= 1'b0;
        end else if (i_take) begin
            r_lead_pending <= n_lead_pending;
            r_lead_value   <= n_lead_value;
            r_halted       <= n_halted;
        end
    end

endmodule

FILE: rtl/gbk_emit.sv
module gbk_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  gbk_pkg::t_burst    i_burst,
    output logic               o_rdy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gbk_pkg::t_out_beat o_out_beat
);
    import gbk_pkg::*;

    logic             r_busy;
    t_burst           r_burst;
    logic [CNT_W-1:0] r_idx;

    logic fire;
    logic final_beat;

    assign fire       = r_busy && !i_out_stall;
    assign final_beat = r_idx == (r_burst.cnt - CNT_ONE);
    assign o_rdy      = !r_busy || (fire && final_beat);

    // Burst register and beat index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire && final_beat) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    // Beat fields from the held burst
    assign o_out_valid = r_busy;

    always_comb begin
        o_out_beat          = '0;
        o_out_beat.out_byte = r_burst.err ? err_char(r_idx)
                                          : (r_idx[0] ? r_burst.b1 : r_burst.b0);
        o_out_beat.run_end  = final_beat;
        o_out_beat.text_done = final_beat && (r_burst.last || r_burst.err);
        o_out_beat.text_ok   = final_beat && r_burst.last && !r_burst.err;
    end

endmodule

FILE: rtl/gbk_checker.sv
module gbk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input gbk_pkg::t_out_beat o_out_beat
);
    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // ok only comes with the closing beat
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.text_ok |-> o_out_beat.text_done)
        else $error("text_ok without text_done");

    // closing a string also ends the run of its input
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.text_done |-> o_out_beat.run_end)
        else $error("text_done without run_end");

    // a failed string closes on the '>' of the marker
    a_err_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.text_done && !o_out_beat.text_ok
        |-> o_out_beat.out_byte == 8'h3E)
        else $error("error close not on marker end");

endmodule

bind gbk_byte_stream_validator gbk_checker u_gbk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
